>>> hw/rtl/cbl_pkg.sv
// ----------------------------------------------------------------------------
// cbl_pkg: shared types, constants and chart tables
// Fixed-point formats, status codes, the four chart curves and the structs
// that travel between the pipeline sections of the chart lookup.
// ----------------------------------------------------------------------------
package cbl_pkg;

  // Chart geometry and fixed-point limits.
  localparam int NUM_CURVES    = 4;
  localparam int KNOT_TOTAL    = 52;
  localparam int MAX_SEG       = 17;
  localparam int DEG_MULT      = 117342;
  localparam int DEG_ROUND     = 32768;
  localparam int ANGLE_MAX_RAD = 12867;
  localparam int MACH_ONE      = 16384;
  localparam int MACH_LOW      = 11469;
  localparam int DEG_CLAMP     = 15360;
  localparam int BAND_WIDTH    = 3840;
  localparam int HALF_BAND     = BAND_WIDTH / 2;
  localparam int LAST_BAND     = NUM_CURVES;
  localparam int KNOT_SHIFT    = 8;
  localparam int OUT_ROUND     = 128;
  localparam int DELTA_MAX     = 65535;

  // Widths of internal values.
  localparam int IN_W        = 16;
  localparam int MACH_W      = 15;
  localparam int ANG_W       = 14;
  localparam int PROD_W      = 31;
  localparam int DEG_W       = 15;
  localparam int A_W         = 14;
  localparam int BAND_W      = 3;
  localparam int FRAC_W      = 12;
  localparam int SEG_W       = 5;
  localparam int IDX_W       = 6;
  localparam int KSEL_W      = 2;
  localparam int Y_W         = 16;
  localparam int DX_W        = 10;
  localparam int ADY_W       = 11;
  localparam int Q_W         = 19;
  localparam int NUM_W       = DX_W + Q_W;
  localparam int VAL_W       = 26;
  localparam int DIFF_W      = 23;
  localparam int MUL_W       = DIFF_W + FRAC_W;
  localparam int NN_W        = 27;
  localparam int RECIP_W     = 28;
  localparam int RPROD_W     = NN_W + RECIP_W;
  localparam int RECIP_SHIFT = 31;
  localparam int QA_W        = RPROD_W - RECIP_SHIFT;
  localparam int DOUT_W      = 16;

  // Division by the band width is a shift by eight and a division by fifteen,
  // done as a multiplication by a rounded-up reciprocal (exact below 2**27).
  localparam int BAND_SUB = BAND_WIDTH >> KNOT_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_BAND =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BAND_SUB) - 64'd1) / 64'(BAND_SUB));

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NEG        = 2'd1;
  localparam logic [1:0] ST_MACH_HIGH  = 2'd2;
  localparam logic [1:0] ST_ANGLE_HIGH = 2'd3;

  // Codes for the argument that failed a check.
  localparam logic [1:0] ARG_NONE  = 2'd0;
  localparam logic [1:0] ARG_MACH  = 2'd1;
  localparam logic [1:0] ARG_ANGLE = 2'd2;

  // Curve layout inside the knot tables.
  localparam int CURVE_START [NUM_CURVES] = '{0, 7, 17, 33};
  localparam int CURVE_LEN   [NUM_CURVES] = '{7, 10, 16, 19};

  // Knot positions on the ratio axis, Q1.14.
  localparam logic [MACH_W-1:0] KNOT_X [KNOT_TOTAL] = '{
    15'd11469, 15'd12327, 15'd13142, 15'd13940, 15'd14766, 15'd15541, 15'd16384,
    15'd11469, 15'd12308, 15'd13121, 15'd14007, 15'd14599, 15'd15052, 15'd15493,
    15'd15817, 15'd16056, 15'd16384,
    15'd11469, 15'd11865, 15'd12314, 15'd12811, 15'd13235, 15'd13690, 15'd14063,
    15'd14363, 15'd14696, 15'd14998, 15'd15259, 15'd15542, 15'd15737, 15'd15936,
    15'd16112, 15'd16384,
    15'd11469, 15'd12064, 15'd12539, 15'd12932, 15'd13277, 15'd13658, 15'd14040,
    15'd14415, 15'd14666, 15'd14922, 15'd15079, 15'd15207, 15'd15359, 15'd15566,
    15'd15731, 15'd15888, 15'd16036, 15'd16173, 15'd16384
  };

  // Knot values, Q0.16.
  localparam logic [Y_W-1:0] KNOT_Y [KNOT_TOTAL] = '{
    16'd834, 16'd826, 16'd826, 16'd775, 16'd663, 16'd429, 16'd0,
    16'd2957, 16'd2861, 16'd2663, 16'd2343, 16'd1981, 16'd1680, 16'd1264,
    16'd884, 16'd572, 16'd0,
    16'd6050, 16'd5886, 16'd5661, 16'd5363, 16'd5046, 16'd4690, 16'd4327,
    16'd3999, 16'd3609, 16'd3154, 16'd2756, 16'd2203, 16'd1771, 16'd1264,
    16'd773, 16'd0,
    16'd10287, 16'd9457, 16'd8781, 16'd8199, 16'd7698, 16'd7103, 16'd6439,
    16'd5789, 16'd5326, 16'd4775, 16'd4418, 16'd4101, 16'd3715, 16'd3154,
    16'd2707, 16'd2203, 16'd1615, 16'd1052, 16'd0
  };

  // Check outcome and the echoed arguments of one transaction.
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        bad;
    logic [DEG_W-1:0]  deg;
    logic [MACH_W-1:0] mach;
  } rpt_t;

  // Left knot value and slope sign of one curve segment.
  typedef struct packed {
    logic [Y_W-1:0] y0;
    logic           neg;
  } base_t;

  // Everything that rides alongside the quotient pipeline.
  typedef struct packed {
    base_t             lo;
    base_t             hi;
    logic              lo_zero;
    logic [FRAC_W-1:0] frac;
    rpt_t              rpt;
  } side_t;

  // One divider lane: rounded numerator and segment span.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DX_W-1:0]  span;
  } div_in_t;

endpackage

>>> hw/rtl/chart_bilinear_lookup_top.sv
// ----------------------------------------------------------------------------
// chart_bilinear_lookup_top: two-axis chart lookup in fixed point
// Checks a Mach ratio and a sweep angle, then interpolates a chart value
// along the ratio on two curves and between them on the angle.
// ----------------------------------------------------------------------------
// The block takes one query transaction per clock cycle while no result is
// stalled and returns one result transaction per query, in order. An
// accepted query passes four setup stages, the 19 stages of the pipelined
// divider that produces one quotient bit per stage for the curve slope, and
// five stages of interpolation and formatting. Each stage holds its
// transaction while the stage after it is full and cannot move on, so a
// stalled result keeps the queries behind it in place and none is lost or repeated.
module chart_bilinear_lookup_top import cbl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    query_valid,
  output logic                    query_stall,
  input  logic signed [IN_W-1:0]  mach_ratio,
  input  logic signed [IN_W-1:0]  sweep_angle,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [DOUT_W-1:0]       delta_value,
  output logic [1:0]              status,
  output logic [1:0]              bad_argument,
  output logic [DEG_W-1:0]        angle_degrees,
  output logic [MACH_W-1:0]       mach_report
);

  logic           front_valid;
  logic           front_stall;
  div_in_t        lo_div;
  div_in_t        hi_div;
  side_t          front_side;

  logic           div_valid;
  logic           div_stall;
  logic [Q_W-1:0] q_lo;
  logic [Q_W-1:0] q_hi;
  side_t          div_side;

  // Checks, clamps and segment setup.
  cbl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (query_valid),
    .in_stall    (query_stall),
    .mach_ratio  (mach_ratio),
    .sweep_angle (sweep_angle),
    .out_valid   (front_valid),
    .out_stall   (front_stall),
    .lo_div      (lo_div),
    .hi_div      (hi_div),
    .side        (front_side)
  );

  // Slope division for both curves.
  cbl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .lo_div    (lo_div),
    .hi_div    (hi_div),
    .in_side   (front_side),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .q_lo      (q_lo),
    .q_hi      (q_hi),
    .out_side  (div_side)
  );

  // Angle interpolation and result register.
  cbl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (div_valid),
    .in_stall      (div_stall),
    .q_lo          (q_lo),
    .q_hi          (q_hi),
    .in_side       (div_side),
    .out_valid     (result_valid),
    .out_stall     (result_stall),
    .delta_value   (delta_value),
    .status        (status),
    .bad_argument  (bad_argument),
    .angle_degrees (angle_degrees),
    .mach_report   (mach_report)
  );

endmodule

>>> hw/rtl/cbl_front.sv
// ----------------------------------------------------------------------------
// cbl_front: argument checks, degree conversion and segment setup
// Four stages: checks and degree product, clamps with band and segment
// search, knot lookup, and the rounded numerator for each curve lane.
// ----------------------------------------------------------------------------
module cbl_front import cbl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  mach_ratio,
  input  logic signed [IN_W-1:0]  sweep_angle,
  output logic                    out_valid,
  input  logic                    out_stall,
  output div_in_t                 lo_div,
  output div_in_t                 hi_div,
  output side_t                   side
);

  localparam int DEPTH = 4;

  typedef struct packed {
    logic [DX_W-1:0]  dx;
    logic [DX_W-1:0]  span;
    logic [ADY_W-1:0] ady;
    logic             neg;
    logic [Y_W-1:0]   y0;
  } lane_t;

  // Segment geometry of curve k at ratio x.
  function automatic lane_t lane_lookup(input logic [KSEL_W-1:0] k,
                                        input logic [SEG_W-1:0] seg_k,
                                        input logic [MACH_W-1:0] x);
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  idx_n;
    logic [MACH_W-1:0] x0;
    logic [MACH_W-1:0] x1;
    logic [Y_W-1:0]    y0;
    logic [Y_W-1:0]    y1;
    lane_t             r;
    idx    = IDX_W'(CURVE_START[k]) + IDX_W'(seg_k);
    idx_n  = idx + IDX_W'(1);
    x0     = KNOT_X[idx];
    x1     = KNOT_X[idx_n];
    y0     = KNOT_Y[idx];
    y1     = KNOT_Y[idx_n];
    r.dx   = DX_W'(x - x0);
    r.span = DX_W'(x1 - x0);
    r.neg  = (y1 < y0);
    r.ady  = r.neg ? ADY_W'(y0 - y1) : ADY_W'(y1 - y0);
    r.y0   = y0;
    return r;
  endfunction

  logic [DEPTH-1:0] vld;
  logic [DEPTH:0]   ld;

  // Stage registers.
  logic [1:0]        s0_status;
  logic [1:0]        s0_bad;
  logic [MACH_W-1:0] s0_mach;
  logic [PROD_W-1:0] s0_prod;

  logic [MACH_W-1:0] s1_x;
  logic [BAND_W-1:0] s1_band;
  logic [FRAC_W-1:0] s1_frac;
  logic [SEG_W-1:0]  s1_seg [NUM_CURVES];
  rpt_t              s1_rpt;

  lane_t             s2_lo;
  lane_t             s2_hi;
  logic              s2_lo_zero;
  logic [FRAC_W-1:0] s2_frac;
  rpt_t              s2_rpt;

  // Combinational values.
  logic [1:0]          chk_status;
  logic [1:0]          chk_bad;
  logic [PROD_W:0]     deg_sum;
  logic [DEG_W-1:0]    deg;
  logic [A_W-1:0]      a_clamp;
  logic [A_W-1:0]      band_base;
  logic [BAND_W-1:0]   band;
  logic [MACH_W-1:0]   x_clamp;
  logic [SEG_W-1:0]    seg [NUM_CURVES];
  logic [KSEL_W-1:0]   k_lo;
  logic [KSEL_W-1:0]   k_hi;
  lane_t               lane_lo;
  lane_t               lane_hi;
  logic [ADY_W+DX_W-1:0] mul_lo;
  logic [ADY_W+DX_W-1:0] mul_hi;

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    ld[DEPTH] = !out_stall;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ld[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[i-1];
        end
      end
    end
  end

  // Argument checks in priority order.
  always_comb begin
    if (mach_ratio[IN_W-1]) begin
      chk_status = ST_NEG;
      chk_bad    = ARG_MACH;
    end else if (sweep_angle[IN_W-1]) begin
      chk_status = ST_NEG;
      chk_bad    = ARG_ANGLE;
    end else if (mach_ratio[MACH_W-1:0] > MACH_W'(MACH_ONE)) begin
      chk_status = ST_MACH_HIGH;
      chk_bad    = ARG_MACH;
    end else if (sweep_angle[MACH_W-1:0] > MACH_W'(ANGLE_MAX_RAD)) begin
      chk_status = ST_ANGLE_HIGH;
      chk_bad    = ARG_ANGLE;
    end else begin
      chk_status = ST_OK;
      chk_bad    = ARG_NONE;
    end
  end

  // Stage 0: checks and the radians-to-degrees product.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_status <= chk_status;
      s0_bad    <= chk_bad;
      s0_mach   <= mach_ratio[MACH_W-1:0];
      s0_prod   <= PROD_W'(sweep_angle[ANG_W-1:0]) * PROD_W'(DEG_MULT);
    end
  end

  // Degrees, clamps, angle band and fraction.
  always_comb begin
    deg_sum = {1'b0, s0_prod} + (PROD_W+1)'(DEG_ROUND);
    deg     = deg_sum[16 +: DEG_W];
    a_clamp = (deg > DEG_W'(DEG_CLAMP)) ? A_W'(DEG_CLAMP) : deg[A_W-1:0];
    x_clamp = (s0_mach < MACH_W'(MACH_LOW)) ? MACH_W'(MACH_LOW) : s0_mach;
    if (a_clamp >= A_W'(4 * BAND_WIDTH)) begin
      band      = BAND_W'(4);
      band_base = A_W'(4 * BAND_WIDTH);
    end else if (a_clamp >= A_W'(3 * BAND_WIDTH)) begin
      band      = BAND_W'(3);
      band_base = A_W'(3 * BAND_WIDTH);
    end else if (a_clamp >= A_W'(2 * BAND_WIDTH)) begin
      band      = BAND_W'(2);
      band_base = A_W'(2 * BAND_WIDTH);
    end else if (a_clamp >= A_W'(BAND_WIDTH)) begin
      band      = BAND_W'(1);
      band_base = A_W'(BAND_WIDTH);
    end else begin
      band      = '0;
      band_base = '0;
    end
  end

  // Segment search: count the inner knots that lie below the ratio.
  always_comb begin
    for (int k = 0; k < NUM_CURVES; k++) begin
      seg[k] = '0;
      for (int j = 0; j < MAX_SEG; j++) begin
        if ((j + 2 < CURVE_LEN[k]) && (x_clamp > KNOT_X[CURVE_START[k] + j + 1])) begin
          seg[k] = seg[k] + SEG_W'(1);
        end
      end
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_x           <= x_clamp;
      s1_band        <= band;
      s1_frac        <= FRAC_W'(a_clamp - band_base);
      s1_seg         <= seg;
      s1_rpt.status  <= s0_status;
      s1_rpt.bad     <= s0_bad;
      s1_rpt.deg     <= deg;
      s1_rpt.mach    <= s0_mach;
    end
  end

  // Curve pair for the band; the top band uses the last curve alone.
  always_comb begin
    if (s1_band == BAND_W'(LAST_BAND)) begin
      k_hi = KSEL_W'(NUM_CURVES - 1);
      k_lo = KSEL_W'(NUM_CURVES - 1);
    end else begin
      k_hi = s1_band[KSEL_W-1:0];
      k_lo = s1_band[KSEL_W-1:0] - KSEL_W'(1);
    end
    lane_lo = lane_lookup(k_lo, s1_seg[k_lo], s1_x);
    lane_hi = lane_lookup(k_hi, s1_seg[k_hi], s1_x);
  end

  // Stage 2: knot lookup.
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_lo      <= lane_lo;
      s2_hi      <= lane_hi;
      s2_lo_zero <= (s1_band == '0);
      s2_frac    <= s1_frac;
      s2_rpt     <= s1_rpt;
    end
  end

  // Numerators with half a span added for rounding to nearest.
  assign mul_lo = s2_lo.ady * s2_lo.dx;
  assign mul_hi = s2_hi.ady * s2_hi.dx;

  // Stage 3: divider inputs and the side data.
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      lo_div.num     <= NUM_W'({mul_lo, KNOT_SHIFT'(0)}) + NUM_W'(s2_lo.span >> 1);
      lo_div.span    <= s2_lo.span;
      hi_div.num     <= NUM_W'({mul_hi, KNOT_SHIFT'(0)}) + NUM_W'(s2_hi.span >> 1);
      hi_div.span    <= s2_hi.span;
      side.lo.y0     <= s2_lo.y0;
      side.lo.neg    <= s2_lo.neg;
      side.hi.y0     <= s2_hi.y0;
      side.hi.neg    <= s2_hi.neg;
      side.lo_zero   <= s2_lo_zero;
      side.frac      <= s2_frac;
      side.rpt       <= s2_rpt;
    end
  end

endmodule

>>> hw/rtl/cbl_div.sv
// ----------------------------------------------------------------------------
// cbl_div: pipelined restoring divider, two lanes
// One quotient bit per stage for the lower and upper curve of each
// transaction; the side data travels along with the partial results.
// ----------------------------------------------------------------------------
module cbl_div import cbl_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  div_in_t        lo_div,
  input  div_in_t        hi_div,
  input  side_t          in_side,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [Q_W-1:0] q_lo,
  output logic [Q_W-1:0] q_hi,
  output side_t          out_side
);

  localparam int DEPTH = Q_W;

  typedef struct packed {
    logic [DX_W-1:0] rem;
    logic [Q_W-1:0]  low;
    logic [Q_W-1:0]  quo;
    logic [DX_W-1:0] den;
  } dstep_t;

  // Initial partial remainder: the top bits are already below the divisor.
  function automatic dstep_t div_init(input div_in_t d);
    dstep_t s;
    s.rem = d.num[NUM_W-1 -: DX_W];
    s.low = d.num[Q_W-1:0];
    s.quo = '0;
    s.den = d.span;
    return s;
  endfunction

  // One restoring step: shift in a numerator bit, subtract when it fits.
  function automatic dstep_t div_step(input dstep_t s);
    logic [DX_W:0] trial;
    logic          fits;
    dstep_t        r;
    trial = {s.rem, s.low[Q_W-1]};
    fits  = (trial >= {1'b0, s.den});
    r.rem = fits ? DX_W'(trial - {1'b0, s.den}) : trial[DX_W-1:0];
    r.low = {s.low[Q_W-2:0], 1'b0};
    r.quo = {s.quo[Q_W-2:0], fits};
    r.den = s.den;
    return r;
  endfunction

  logic [DEPTH-1:0] vld;
  logic [DEPTH:0]   ld;
  dstep_t           st_lo [DEPTH];
  dstep_t           st_hi [DEPTH];
  side_t            st_side [DEPTH];

  // Stage enables.
  always_comb begin
    ld[DEPTH] = !out_stall;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ld[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[i-1];
        end
      end
    end
  end

  // Quotient stages.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ld[i]) begin
        if (i == 0) begin
          st_lo[i]   <= div_step(div_init(lo_div));
          st_hi[i]   <= div_step(div_init(hi_div));
          st_side[i] <= in_side;
        end else begin
          st_lo[i]   <= div_step(st_lo[i-1]);
          st_hi[i]   <= div_step(st_hi[i-1]);
          st_side[i] <= st_side[i-1];
        end
      end
    end
  end

  assign q_lo     = st_lo[DEPTH-1].quo;
  assign q_hi     = st_hi[DEPTH-1].quo;
  assign out_side = st_side[DEPTH-1];

endmodule

>>> hw/rtl/cbl_back.sv
// ----------------------------------------------------------------------------
// cbl_back: curve values, angle interpolation and result formatting
// Five stages: curve values, difference, product with the angle fraction,
// reciprocal division by the band width, and the rounded, masked result.
// ----------------------------------------------------------------------------
module cbl_back import cbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [Q_W-1:0]    q_lo,
  input  logic [Q_W-1:0]    q_hi,
  input  side_t             in_side,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DOUT_W-1:0] delta_value,
  output logic [1:0]        status,
  output logic [1:0]        bad_argument,
  output logic [DEG_W-1:0]  angle_degrees,
  output logic [MACH_W-1:0] mach_report
);

  localparam int DEPTH = 5;

  // Curve value in Q0.24: left knot value plus the signed rounded step.
  function automatic logic signed [VAL_W-1:0] curve_val(input base_t b,
                                                       input logic [Q_W-1:0] q);
    logic signed [VAL_W-1:0] base;
    logic signed [VAL_W-1:0] step;
    base = VAL_W'({b.y0, KNOT_SHIFT'(0)});
    step = VAL_W'(q);
    return b.neg ? (base - step) : (base + step);
  endfunction

  logic [DEPTH-1:0] vld;
  logic [DEPTH:0]   ld;

  logic signed [VAL_W-1:0] b0_lo;
  logic signed [VAL_W-1:0] b0_hi;
  logic [FRAC_W-1:0]       b0_frac;
  rpt_t                    b0_rpt;

  logic signed [VAL_W-1:0] b1_lo;
  logic [DIFF_W-1:0]       b1_ad;
  logic                    b1_neg;
  logic [FRAC_W-1:0]       b1_frac;
  rpt_t                    b1_rpt;

  logic signed [VAL_W-1:0] b2_lo;
  logic [MUL_W-1:0]        b2_mp;
  logic                    b2_neg;
  rpt_t                    b2_rpt;

  logic signed [VAL_W-1:0] b3_lo;
  logic [RPROD_W-1:0]      b3_rp;
  logic                    b3_neg;
  rpt_t                    b3_rpt;

  logic signed [VAL_W-1:0] diff;
  logic [MUL_W:0]          nsum;
  logic [NN_W-1:0]         nn;
  logic [QA_W-1:0]         qa;
  logic signed [VAL_W-1:0] r24;
  logic [VAL_W-1:0]        dsum;
  logic [VAL_W-KNOT_SHIFT-1:0] dd;
  logic [DOUT_W-1:0]       delta;

  // Stage enables.
  always_comb begin
    ld[DEPTH] = !out_stall;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ld[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[i-1];
        end
      end
    end
  end

  // Stage 0: both curve values; the lowest band sits on the zero curve.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      b0_lo   <= in_side.lo_zero ? '0 : curve_val(in_side.lo, q_lo);
      b0_hi   <= curve_val(in_side.hi, q_hi);
      b0_frac <= in_side.frac;
      b0_rpt  <= in_side.rpt;
    end
  end

  // Stage 1: magnitude and sign of the curve difference.
  assign diff = b0_hi - b0_lo;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      b1_lo   <= b0_lo;
      b1_neg  <= diff[VAL_W-1];
      b1_ad   <= diff[VAL_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      b1_frac <= b0_frac;
      b1_rpt  <= b0_rpt;
    end
  end

  // Stage 2: product with the angle fraction.
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      b2_lo  <= b1_lo;
      b2_mp  <= b1_ad * b1_frac;
      b2_neg <= b1_neg;
      b2_rpt <= b1_rpt;
    end
  end

  // Stage 3: add half a band, drop eight bits, multiply by 1/15.
  assign nsum = {1'b0, b2_mp} + (MUL_W+1)'(HALF_BAND);
  assign nn   = nsum[KNOT_SHIFT +: NN_W];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      b3_lo  <= b2_lo;
      b3_rp  <= RPROD_W'(nn) * RPROD_W'(RECIP_BAND);
      b3_neg <= b2_neg;
      b3_rpt <= b2_rpt;
    end
  end

  // Final value, rounding to Q0.16 and saturation.
  always_comb begin
    qa   = b3_rp[RECIP_SHIFT +: QA_W];
    r24  = b3_neg ? (b3_lo - VAL_W'(qa)) : (b3_lo + VAL_W'(qa));
    dsum = VAL_W'(r24) + VAL_W'(OUT_ROUND);
    dd   = dsum[VAL_W-1:KNOT_SHIFT];
    if (r24[VAL_W-1]) begin
      delta = '0;
    end else if (dd > (VAL_W-KNOT_SHIFT)'(DELTA_MAX)) begin
      delta = DOUT_W'(DELTA_MAX);
    end else begin
      delta = dd[DOUT_W-1:0];
    end
  end

  // Stage 4: output register; a failed check clears the numeric fields.
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      status       <= b3_rpt.status;
      bad_argument <= b3_rpt.bad;
      if (b3_rpt.status == ST_OK) begin
        delta_value   <= delta;
        angle_degrees <= b3_rpt.deg;
        mach_report   <= b3_rpt.mach;
      end else begin
        delta_value   <= '0;
        angle_degrees <= '0;
        mach_report   <= '0;
      end
    end
  end

endmodule
